FILE: sv/ucs_pkg.sv
// types, character constants and the host/port/path/query/fragment parse step of the url component splitter
package ucs_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        COMP_SCHEME = 3'd0,
        COMP_USER   = 3'd1,
        COMP_PASS   = 3'd2,
        COMP_HOST   = 3'd3,
        COMP_PORT   = 3'd4,
        COMP_PATH   = 3'd5,
        COMP_QUERY  = 3'd6,
        COMP_FRAG   = 3'd7
    } comp_t;

    typedef enum logic [2:0] {
        ERR_NO_COLON   = 3'd0,
        ERR_BAD_SCHEME = 3'd1,
        ERR_NO_SLASH   = 3'd2,
        ERR_TRAILING   = 3'd3,
        ERR_OVERFLOW   = 3'd4
    } err_t;

    // parse position within the url
    typedef enum logic [9:0] {
        PH_SCHEME = 10'b00_0000_0001,
        PH_SLASH  = 10'b00_0000_0010,
        PH_AUTH   = 10'b00_0000_0100,
        PH_HSTART = 10'b00_0000_1000,
        PH_HOST   = 10'b00_0001_0000,
        PH_AFTV6  = 10'b00_0010_0000,
        PH_PORT   = 10'b00_0100_0000,
        PH_PATH   = 10'b00_1000_0000,
        PH_QUERY  = 10'b01_0000_0000,
        PH_FRAG   = 10'b10_0000_0000
    } phase_t;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b00_0001,
        ST_RD    = 6'b00_0010,
        ST_PROC  = 6'b00_0100,
        ST_POST  = 6'b00_1000,
        ST_FINAL = 6'b01_0000,
        ST_FLUSH = 6'b10_0000
    } st_t;

    typedef struct packed {
        kind_t      kind;
        comp_t      component;
        logic [7:0] out_char;
        err_t       error_code;
    } res_t;

    typedef struct packed {
        phase_t phase;
        logic   ipv6;
        logic   emit;
        comp_t  comp;
        logic   fail;
    } feed_t;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // one character of host, port, path, query or fragment
    function automatic feed_t feed_char(phase_t ph, logic v6, logic [7:0] c);
        feed_t f;
        f.phase = ph;
        f.ipv6  = v6;
        f.emit  = 1'b0;
        f.comp  = COMP_HOST;
        f.fail  = 1'b0;
        if (ph == PH_HSTART) begin
            f.ipv6  = (c == CH_LBRACK);
            f.phase = PH_HOST;
        end
        unique case (f.phase)
            PH_HOST: begin
                if (f.ipv6 && c == CH_RBRACK) f.phase = PH_AFTV6;
                else if (!f.ipv6 && c == CH_COLON) f.phase = PH_PORT;
                else if (!f.ipv6 && c == CH_SLASH) f.phase = PH_PATH;
                else begin
                    f.emit = 1'b1;
                    f.comp = COMP_HOST;
                end
            end
            PH_AFTV6: begin
                if (c == CH_COLON) f.phase = PH_PORT;
                else if (c == CH_SLASH) f.phase = PH_PATH;
                else f.fail = 1'b1;
            end
            PH_PORT: begin
                if (c == CH_SLASH) f.phase = PH_PATH;
                else begin
                    f.emit = 1'b1;
                    f.comp = COMP_PORT;
                end
            end
            PH_PATH: begin
                if (c == CH_QMARK) f.phase = PH_QUERY;
                else if (c == CH_HASH) f.phase = PH_FRAG;
                else begin
                    f.emit = 1'b1;
                    f.comp = COMP_PATH;
                end
            end
            PH_QUERY: begin
                if (c == CH_HASH) f.phase = PH_FRAG;
                else begin
                    f.emit = 1'b1;
                    f.comp = COMP_QUERY;
                end
            end
            PH_FRAG: begin
                f.emit = 1'b1;
                f.comp = COMP_FRAG;
            end
            default: begin
            end
        endcase
        return f;
    endfunction

endpackage

FILE: sv/url_component_splitter.sv
// url component splitter: one url character in, tagged component characters out
//
//  channel   ports                                          direction
//  s_        s_valid s_ready s_ch[7:0] s_last               in, one url character per transfer
//  m_        m_valid m_ready m_kind m_component m_out_char  out, one result per transfer
//            m_error_code m_run_end
//
//  a last character is followed by a final step (final result), then a close step
//  '@' in the authority replays the held bytes as user and password, an address step
//  then a registered read-data step per byte; '/' there replays them as host, then the '/'
//  a url that ends inside the authority replays as host before its final result
//  reset (aresetn low at a clock edge) returns to the scheme phase; memory is not cleared
//  s_ready drops during replay and final steps, and whenever m_ stalls with a held result
module url_component_splitter #(
    parameter int AUTH_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_ch,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ucs_pkg::kind_t        m_kind,
    output ucs_pkg::comp_t        m_component,
    output logic [7:0]            m_out_char,
    output ucs_pkg::err_t         m_error_code,
    output logic                  m_run_end
);
    import ucs_pkg::*;

    localparam int FW = $clog2(AUTH_DEPTH + 1);
    localparam int AW = $clog2(AUTH_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(AUTH_DEPTH);

    // authority buffer, one write and one registered read port
    logic [7:0] mem [AUTH_DEPTH];
    logic [7:0] rdata_reg;
    logic          mem_we;

    // control state
    st_t           st_reg, st_next;
    phase_t        phase_reg, phase_next;
    logic          slash_reg, slash_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          ipv6_reg, ipv6_next;
    logic          failed_reg, failed_next;
    err_t          reason_reg, reason_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic          user_mode_reg, user_mode_next;
    logic          pw_reg, pw_next;
    logic          slash_pend_reg, slash_pend_next;
    logic          hold_valid_reg, hold_valid_next;
    logic          m_valid_reg, m_valid_next;

    // payload
    res_t          hold_res_reg, hold_res_next;
    res_t          out_res_reg, out_res_next;
    logic          out_end_reg, out_end_next;
    logic          last_reg, last_next;
    logic          full_reg, full_next;

    logic          can_push;
    logic          go;
    logic          in_fire;
    logic          pr_req;
    res_t          pr_res;
    feed_t         fd_in, fd_mem, fd_sl;

    // output register is free this cycle
    assign can_push = !m_valid_reg || m_ready;
    // a new result may enter the hold stage
    assign go       = !hold_valid_reg || can_push;
    assign s_ready  = (st_reg == ST_IDLE) && can_push;
    assign in_fire  = s_valid && s_ready;

    assign fd_in  = feed_char(phase_reg, ipv6_reg, s_ch);
    assign fd_mem = feed_char(phase_reg, ipv6_reg, rdata_reg);
    assign fd_sl  = feed_char(phase_reg, ipv6_reg, CH_SLASH);

    always_comb begin
        logic  demit;
        res_t  dres;
        logic  rep_user;
        logic  rep_host;
        logic  fin_prod;
        res_t  fin_res;
        st_t   after;

        st_next         = st_reg;
        phase_next      = phase_reg;
        slash_next      = slash_reg;
        fill_next       = fill_reg;
        ipv6_next       = ipv6_reg;
        failed_next     = failed_reg;
        reason_next     = reason_reg;
        idx_next        = idx_reg;
        user_mode_next  = user_mode_reg;
        pw_next         = pw_reg;
        slash_pend_next = slash_pend_reg;
        hold_valid_next = hold_valid_reg;
        hold_res_next   = hold_res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_res_next    = out_res_reg;
        out_end_next    = out_end_reg;
        last_next       = last_reg;
        full_next       = full_reg;
        mem_we          = 1'b0;
        pr_req          = 1'b0;

        pr_res.kind       = KIND_CHAR;
        pr_res.component  = COMP_SCHEME;
        pr_res.out_char   = 8'h00;
        pr_res.error_code = ERR_NO_COLON;

        demit    = 1'b0;
        dres     = pr_res;
        dres.out_char = s_ch;
        rep_user = 1'b0;
        rep_host = 1'b0;
        fin_prod = 1'b0;
        fin_res  = pr_res;
        after    = last_reg ? ST_FINAL : ST_FLUSH;

        unique case (st_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    last_next = s_last;
                    if (phase_reg == PH_SCHEME) begin
                        if (s_ch == CH_COLON) begin
                            phase_next = PH_SLASH;
                        end else if (!failed_reg) begin
                            if (s_ch >= CH_UP_A && s_ch <= CH_UP_Z) begin
                                demit = 1'b1;
                                dres.out_char = s_ch | CASE_BIT;
                            end else if ((s_ch >= CH_LO_A && s_ch <= CH_LO_Z) ||
                                         s_ch == CH_PLUS || s_ch == CH_MINUS ||
                                         s_ch == CH_DOT) begin
                                demit = 1'b1;
                            end else begin
                                failed_next = 1'b1;
                                reason_next = ERR_BAD_SCHEME;
                            end
                        end
                    end else if (!failed_reg) begin
                        if (phase_reg == PH_SLASH) begin
                            if (s_ch != CH_SLASH) begin
                                failed_next = 1'b1;
                                reason_next = ERR_NO_SLASH;
                            end else if (slash_reg) begin
                                slash_next = 1'b0;
                                phase_next = PH_AUTH;
                                fill_next  = '0;
                            end else begin
                                slash_next = 1'b1;
                            end
                        end else if (phase_reg == PH_AUTH) begin
                            if (s_ch == CH_AT) begin
                                rep_user = 1'b1;
                            end else if (s_ch == CH_SLASH) begin
                                rep_host  = 1'b1;
                                full_next = (fill_reg >= DEPTH_F);
                            end else if (fill_reg >= DEPTH_F) begin
                                failed_next = 1'b1;
                                reason_next = ERR_OVERFLOW;
                            end else begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + FW'(1);
                            end
                        end else begin
                            phase_next     = fd_in.phase;
                            ipv6_next      = fd_in.ipv6;
                            demit          = fd_in.emit;
                            dres.component = fd_in.comp;
                            if (fd_in.fail) begin
                                failed_next = 1'b1;
                                reason_next = ERR_TRAILING;
                            end
                        end
                    end

                    if (rep_user) begin
                        user_mode_next = 1'b1;
                        pw_next        = 1'b0;
                        idx_next       = '0;
                        st_next        = ST_RD;
                    end else if (rep_host) begin
                        user_mode_next  = 1'b0;
                        slash_pend_next = 1'b1;
                        phase_next      = PH_HSTART;
                        idx_next        = '0;
                        st_next         = ST_RD;
                    end else if (s_last) begin
                        st_next = ST_FINAL;
                        if (demit) begin
                            pr_req = 1'b1;
                            pr_res = dres;
                        end
                    end else if (demit) begin
                        // single result, straight to the output register
                        m_valid_next = 1'b1;
                        out_res_next = dres;
                        out_end_next = 1'b1;
                    end
                end
            end

            ST_RD: begin
                if (idx_reg >= fill_reg || (!user_mode_reg && failed_reg)) begin
                    fill_next = '0;
                    if (user_mode_reg) begin
                        phase_next = PH_HSTART;
                        st_next    = after;
                    end else if (slash_pend_reg) begin
                        st_next = ST_POST;
                    end else begin
                        st_next = ST_FINAL;
                    end
                end else begin
                    st_next = ST_PROC;
                end
            end

            ST_PROC: begin
                if (user_mode_reg) begin
                    if (!pw_reg && rdata_reg == CH_COLON) begin
                        pw_next  = 1'b1;
                        idx_next = idx_reg + FW'(1);
                        st_next  = ST_RD;
                    end else if (go) begin
                        pr_req           = 1'b1;
                        pr_res.component = pw_reg ? COMP_PASS : COMP_USER;
                        pr_res.out_char  = rdata_reg;
                        idx_next         = idx_reg + FW'(1);
                        st_next          = ST_RD;
                    end
                end else if (!fd_mem.emit || go) begin
                    phase_next = fd_mem.phase;
                    ipv6_next  = fd_mem.ipv6;
                    if (fd_mem.fail) begin
                        failed_next = 1'b1;
                        reason_next = ERR_TRAILING;
                    end
                    if (fd_mem.emit) begin
                        pr_req           = 1'b1;
                        pr_res.component = fd_mem.comp;
                        pr_res.out_char  = rdata_reg;
                    end
                    idx_next = idx_reg + FW'(1);
                    st_next  = ST_RD;
                end
            end

            ST_POST: begin
                // the '/' that ended the authority, after the host replay
                if (failed_reg) begin
                    slash_pend_next = 1'b0;
                    st_next         = after;
                end else if (full_reg && phase_reg == PH_HOST && ipv6_reg) begin
                    failed_next     = 1'b1;
                    reason_next     = ERR_OVERFLOW;
                    slash_pend_next = 1'b0;
                    st_next         = after;
                end else if (!fd_sl.emit || go) begin
                    phase_next = fd_sl.phase;
                    ipv6_next  = fd_sl.ipv6;
                    if (fd_sl.fail) begin
                        failed_next = 1'b1;
                        reason_next = ERR_TRAILING;
                    end
                    if (fd_sl.emit) begin
                        pr_req           = 1'b1;
                        pr_res.component = fd_sl.comp;
                        pr_res.out_char  = CH_SLASH;
                    end
                    slash_pend_next = 1'b0;
                    st_next         = after;
                end
            end

            ST_FINAL: begin
                if (phase_reg == PH_SCHEME) begin
                    fin_prod           = 1'b1;
                    fin_res.kind       = KIND_ERROR;
                    fin_res.error_code = ERR_NO_COLON;
                end else if (failed_reg) begin
                    fin_prod           = 1'b1;
                    fin_res.kind       = KIND_ERROR;
                    fin_res.error_code = reason_reg;
                end else if (phase_reg == PH_SLASH) begin
                    fin_prod           = 1'b1;
                    fin_res.kind       = KIND_ERROR;
                    fin_res.error_code = ERR_NO_SLASH;
                end else if (phase_reg == PH_AUTH) begin
                    // url ended inside the authority: it is host[:port]
                    user_mode_next  = 1'b0;
                    slash_pend_next = 1'b0;
                    phase_next      = PH_HSTART;
                    idx_next        = '0;
                    st_next         = ST_RD;
                end else begin
                    fin_prod     = 1'b1;
                    fin_res.kind = KIND_DONE;
                end
                if (fin_prod && go) begin
                    pr_req      = 1'b1;
                    pr_res      = fin_res;
                    phase_next  = PH_SCHEME;
                    slash_next  = 1'b0;
                    fill_next   = '0;
                    ipv6_next   = 1'b0;
                    failed_next = 1'b0;
                    reason_next = ERR_NO_COLON;
                    st_next     = ST_FLUSH;
                end
            end

            ST_FLUSH: begin
                // held result is the last one of this transfer
                if (!hold_valid_reg) begin
                    st_next = ST_IDLE;
                end else if (can_push) begin
                    m_valid_next    = 1'b1;
                    out_res_next    = hold_res_reg;
                    out_end_next    = 1'b1;
                    hold_valid_next = 1'b0;
                    st_next         = ST_IDLE;
                end
            end

            default: begin
                st_next = ST_IDLE;
            end
        endcase

        // new result enters the hold stage, pushing the older one out
        if (pr_req) begin
            if (hold_valid_reg) begin
                m_valid_next = 1'b1;
                out_res_next = hold_res_reg;
                out_end_next = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_res_next   = pr_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            phase_reg      <= PH_SCHEME;
            slash_reg      <= 1'b0;
            fill_reg       <= '0;
            ipv6_reg       <= 1'b0;
            failed_reg     <= 1'b0;
            reason_reg     <= ERR_NO_COLON;
            idx_reg        <= '0;
            user_mode_reg  <= 1'b0;
            pw_reg         <= 1'b0;
            slash_pend_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg         <= st_next;
            phase_reg      <= phase_next;
            slash_reg      <= slash_next;
            fill_reg       <= fill_next;
            ipv6_reg       <= ipv6_next;
            failed_reg     <= failed_next;
            reason_reg     <= reason_next;
            idx_reg        <= idx_next;
            user_mode_reg  <= user_mode_next;
            pw_reg         <= pw_next;
            slash_pend_reg <= slash_pend_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_res_reg <= hold_res_next;
        out_res_reg  <= out_res_next;
        out_end_reg  <= out_end_next;
        last_reg     <= last_next;
        full_reg     <= full_next;
    end

    // buffer is written only while s_ready is high, read every cycle at the replay index
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[fill_reg[AW-1:0]] <= s_ch;
        end
        rdata_reg <= mem[idx_reg[AW-1:0]];
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = out_res_reg.kind;
    assign m_component  = out_res_reg.component;
    assign m_out_char   = out_res_reg.out_char;
    assign m_error_code = out_res_reg.error_code;
    assign m_run_end    = out_end_reg;

    // hold stage is drained before a new character is taken
    a_idle_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("hold stage occupied while idle");

    // done and error results always close the transfer's results
    a_final_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_CHAR) |-> m_run_end)
        else $error("final result without run end");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_F)
        else $error("authority fill beyond depth");

    a_replay_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_PROC) |-> (idx_reg < fill_reg))
        else $error("replay read beyond held bytes");

    // buffer writes never land while a replay is reading it
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (st_reg == ST_IDLE && phase_reg == PH_AUTH))
        else $error("authority write outside idle");

endmodule

FILE: dv/url_component_splitter_tb.sv
// self-checking testbench of the url component splitter: directed and random urls
`timescale 1ns / 1ps

import ucs_pkg::*;

typedef struct packed {
    kind_t      kind;
    comp_t      component;
    logic [7:0] out_char;
    err_t       error_code;
    logic       run_end;
} url_result_t;

// predicts the tagged characters of each url and checks them in order
class url_scoreboard #(int DEPTH = 32);
    localparam int MAX_PER_CHAR = DEPTH + 1;

    phase_t      ph;
    int unsigned slashes;
    bit [7:0]    held [DEPTH];
    int unsigned fill;
    bit          v6;
    bit          failed;
    err_t        why;

    url_result_t step_q[$];
    url_result_t expected[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
        foreach (held[i]) held[i] = 8'h00;
        restart();
    endfunction

    function void restart();
        ph      = PH_SCHEME;
        slashes = 0;
        fill    = 0;
        v6      = 1'b0;
        failed  = 1'b0;
        why     = ERR_NO_COLON;
    endfunction

    function void emit(kind_t k, comp_t c, bit [7:0] ch, err_t e);
        url_result_t r;
        if (step_q.size() >= MAX_PER_CHAR) return;
        r.kind       = k;
        r.component  = c;
        r.out_char   = ch;
        r.error_code = e;
        r.run_end    = 1'b0;
        step_q.push_back(r);
    endfunction

    // only the first reason of a url counts
    function void reject(err_t r);
        if (!failed) begin
            failed = 1'b1;
            why    = r;
        end
    endfunction

    // host, port, path, query and fragment
    function void parse_tail(bit [7:0] c);
        if (ph == PH_HSTART) begin
            v6 = (c == CH_LBRACK);
            ph = PH_HOST;
        end
        case (ph)
            PH_HOST: begin
                if (v6 && c == CH_RBRACK) ph = PH_AFTV6;
                else if (!v6 && c == CH_COLON) ph = PH_PORT;
                else if (!v6 && c == CH_SLASH) ph = PH_PATH;
                else emit(KIND_CHAR, COMP_HOST, c, ERR_NO_COLON);
            end
            PH_AFTV6: begin
                if (c == CH_COLON) ph = PH_PORT;
                else if (c == CH_SLASH) ph = PH_PATH;
                else reject(ERR_TRAILING);
            end
            PH_PORT: begin
                if (c == CH_SLASH) ph = PH_PATH;
                else emit(KIND_CHAR, COMP_PORT, c, ERR_NO_COLON);
            end
            PH_PATH: begin
                if (c == CH_QMARK) ph = PH_QUERY;
                else if (c == CH_HASH) ph = PH_FRAG;
                else emit(KIND_CHAR, COMP_PATH, c, ERR_NO_COLON);
            end
            PH_QUERY: begin
                if (c == CH_HASH) ph = PH_FRAG;
                else emit(KIND_CHAR, COMP_QUERY, c, ERR_NO_COLON);
            end
            PH_FRAG: begin
                emit(KIND_CHAR, COMP_FRAG, c, ERR_NO_COLON);
            end
            default: begin
            end
        endcase
    endfunction

    function void replay_as_host();
        ph = PH_HSTART;
        for (int unsigned i = 0; i < fill && i < DEPTH && !failed; i++)
            parse_tail(held[i]);
    endfunction

    function void authority_char(bit [7:0] c);
        comp_t comp;
        bit    full;
        if (c == CH_AT) begin
            // user up to the first colon, password keeps any later colon
            comp = COMP_USER;
            for (int unsigned i = 0; i < fill && i < DEPTH; i++) begin
                if (comp == COMP_USER && held[i] == CH_COLON) comp = COMP_PASS;
                else emit(KIND_CHAR, comp, held[i], ERR_NO_COLON);
            end
            fill = 0;
            ph   = PH_HSTART;
        end else if (c == CH_SLASH) begin
            full = (fill >= DEPTH);
            replay_as_host();
            fill = 0;
            if (failed) return;
            if (full && ph == PH_HOST && v6) reject(ERR_OVERFLOW);
            else parse_tail(c);
        end else if (fill >= DEPTH) begin
            reject(ERR_OVERFLOW);
        end else begin
            held[fill] = c;
            fill++;
        end
    endfunction

    function void note_input(bit [7:0] c, bit last);
        step_q.delete();
        if (ph == PH_SCHEME) begin
            if (c == CH_COLON) begin
                ph = PH_SLASH;
            end else if (!failed) begin
                if (c >= CH_UP_A && c <= CH_UP_Z)
                    emit(KIND_CHAR, COMP_SCHEME, c + CASE_BIT, ERR_NO_COLON);
                else if ((c >= CH_LO_A && c <= CH_LO_Z) || c == CH_PLUS ||
                         c == CH_MINUS || c == CH_DOT)
                    emit(KIND_CHAR, COMP_SCHEME, c, ERR_NO_COLON);
                else
                    reject(ERR_BAD_SCHEME);
            end
        end else if (!failed) begin
            if (ph == PH_SLASH) begin
                if (c != CH_SLASH) begin
                    reject(ERR_NO_SLASH);
                end else if (slashes >= 1) begin
                    slashes = 0;
                    ph      = PH_AUTH;
                    fill    = 0;
                end else begin
                    slashes = 1;
                end
            end else if (ph == PH_AUTH) begin
                authority_char(c);
            end else begin
                parse_tail(c);
            end
        end

        if (last) begin
            if (ph == PH_SCHEME) begin
                emit(KIND_ERROR, COMP_SCHEME, 8'h00, ERR_NO_COLON);
            end else if (failed) begin
                emit(KIND_ERROR, COMP_SCHEME, 8'h00, why);
            end else if (ph == PH_SLASH) begin
                emit(KIND_ERROR, COMP_SCHEME, 8'h00, ERR_NO_SLASH);
            end else begin
                if (ph == PH_AUTH) begin
                    replay_as_host();
                    fill = 0;
                end
                if (failed) emit(KIND_ERROR, COMP_SCHEME, 8'h00, why);
                else emit(KIND_DONE, COMP_SCHEME, 8'h00, ERR_NO_COLON);
            end
            restart();
        end

        if (step_q.size() > 0) step_q[step_q.size() - 1].run_end = 1'b1;
        foreach (step_q[i]) expected.push_back(step_q[i]);
    endfunction

    function void check_result(url_result_t got);
        url_result_t want;
        if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind=%0d comp=%0d char=%02h err=%0d end=%0d",
                         got.kind, got.component, got.out_char, got.error_code, got.run_end);
            return;
        end
        want = expected.pop_front();
        if (got.kind !== want.kind || got.component !== want.component ||
            got.out_char !== want.out_char || got.error_code !== want.error_code ||
            got.run_end !== want.run_end) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp kind=%0d comp=%0d char=%02h err=%0d end=%0d",
                         want.kind, want.component, want.out_char, want.error_code,
                         want.run_end);
                $display("          got kind=%0d comp=%0d char=%02h err=%0d end=%0d",
                         got.kind, got.component, got.out_char, got.error_code,
                         got.run_end);
            end
        end
    endfunction

    function int pending();
        return expected.size();
    endfunction
endclass

module url_component_splitter_tb;

    localparam int AUTH_DEPTH   = 32;
    localparam int ITEMS_PER_PH = 65;   // four idling phases, at least 260 characters in all
    localparam int DRAIN_LIMIT  = 200000;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    logic [7:0]     s_ch;
    logic           s_last;
    logic           m_valid;
    logic           m_ready;
    kind_t          m_kind;
    comp_t          m_component;
    logic [7:0]     m_out_char;
    err_t           m_error_code;
    logic           m_run_end;

    url_scoreboard #(AUTH_DEPTH) sb;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_len     = 0;   // receiver hold-off request, cleared by the receiver
    int sent_items;

    bit [7:0] url_q[$];

    url_component_splitter #(
        .AUTH_DEPTH   (AUTH_DEPTH)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ch         (s_ch),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_component  (m_component),
        .m_out_char   (m_out_char),
        .m_error_code (m_error_code),
        .m_run_end    (m_run_end)
    );

    always #5 aclk = ~aclk;

    // safety net against a hung handshake
    initial begin
        #20_000_000;
        $display("** url_component_splitter: FAILED **");
        $finish;
    end

    // both channels are sampled at the same edge; input noted first
    always @(posedge aclk) begin : monitor
        url_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_ch, s_last);
            if (m_valid && m_ready) begin
                got.kind       = m_kind;
                got.component  = m_component;
                got.out_char   = m_out_char;
                got.error_code = m_error_code;
                got.run_end    = m_run_end;
                sb.check_result(got);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // one character transfer; valid only drops when an idle gap follows
    task automatic send_char(input bit [7:0] c, input bit last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        s_last  <= last;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_char(t[i], i == t.len() - 1);
    endtask

    task automatic send_url();
        foreach (url_q[i]) send_char(url_q[i], i == url_q.size() - 1);
    endtask

    function automatic bit [7:0] pick(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    function automatic void push_run(input string set, input int lo, input int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) url_q.push_back(pick(set));
    endfunction

    // mostly well-formed urls with random content, some noise and broken ones
    function automatic void make_url();
        int  shape;
        int  alen;
        int  pos;
        bit  bracket;
        shape = $urandom_range(99);
        url_q.delete();
        if (shape < 10) begin
            repeat ($urandom_range(12, 1)) url_q.push_back(8'($urandom_range(255)));
            return;
        end
        push_run("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+-.", 1, 6);
        url_q.push_back(CH_COLON);
        url_q.push_back(CH_SLASH);
        url_q.push_back(CH_SLASH);
        if ($urandom_range(99) < 15) begin
            // long authority around the buffer depth, maybe an open ipv6 host
            alen    = $urandom_range(AUTH_DEPTH + 3, AUTH_DEPTH - 3);
            bracket = $urandom_range(1);
            if (bracket) url_q.push_back(CH_LBRACK);
            push_run("abcdef0123456789.-", alen - int'(bracket), alen - int'(bracket));
            if (bracket && $urandom_range(1)) url_q.push_back(CH_RBRACK);
        end else begin
            if ($urandom_range(2) == 0) begin
                push_run("abcdefghijklmnopqrstuvwxyz0123456789._~", 1, 5);
                if ($urandom_range(1)) begin
                    url_q.push_back(CH_COLON);
                    push_run("abcdefghijklmnopqrstuvwxyz0123456789:", 1, 4);
                end
                url_q.push_back(CH_AT);
            end
            if ($urandom_range(3) == 0) begin
                url_q.push_back(CH_LBRACK);
                push_run("0123456789abcdef:", 1, 6);
                url_q.push_back(CH_RBRACK);
                if ($urandom_range(7) == 0) url_q.push_back(pick("xyz0"));
            end else begin
                push_run("abcdefghijklmnopqrstuvwxyz0123456789.-", 1, 8);
            end
            if ($urandom_range(1)) begin
                url_q.push_back(CH_COLON);
                push_run("0123456789", 1, 4);
            end
        end
        if ($urandom_range(3) != 0) begin
            url_q.push_back(CH_SLASH);
            push_run("abcdefghijklmnopqrstuvwxyz0123456789/-._~:@", 0, 8);
        end
        if ($urandom_range(2) == 0) begin
            url_q.push_back(CH_QMARK);
            push_run("abcdefghijklmnopqrstuvwxyz=&?/", 0, 5);
        end
        if ($urandom_range(2) == 0) begin
            url_q.push_back(CH_HASH);
            push_run("abcdefghijklmnopqrstuvwxyz#?/", 0, 5);
        end
        if (shape < 30) begin
            // broken sequence: one corrupted byte or a cut-off url
            pos = $urandom_range(url_q.size() - 1);
            if ($urandom_range(1)) url_q[pos] = 8'($urandom_range(255));
            else url_q = url_q[0:pos];
        end
    endfunction

    initial begin : stimulus
        int wait_cnt;
        int target;
        sb         = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_ch       = 8'h00;
        s_last     = 1'b0;
        sent_items = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: byte extremes with no colon, then the slash, scheme and trailing errors and the password rule
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("A:");                // url ends before the slashes
        send_text("h1:");               // bad scheme char, reason kept past the colon
        send_text("a:/x");              // second slash missing
        send_text("s://[1]x");          // data after a closed ipv6 host
        send_text("s://a:b:c@h");       // later colon stays in the password

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
                default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
            endcase
            target = sent_items + ITEMS_PER_PH;
            // long receiver hold-off while the sender keeps offering
            if (p == 0) hold_len = 300;
            while (sent_items < target) begin
                make_url();
                send_url();
            end
        end
        s_valid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (100) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** url_component_splitter: PASSED **");
        end else begin
            $display("** url_component_splitter: FAILED **");
        end
        $finish;
    end

endmodule

FILE: url_component_splitter.f
sv/ucs_pkg.sv
sv/url_component_splitter.sv
dv/url_component_splitter_tb.sv
